>>> src/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// shared types and constants of the line edit buffer
// ----------------------------------------------------------------------------
package leb_pkg;

	typedef enum logic [3:0] {
		MODE_INSERT     = 4'd0,
		MODE_BACKSPACE  = 4'd1,
		MODE_DELETE     = 4'd2,
		MODE_LEFT       = 4'd3,
		MODE_RIGHT      = 4'd4,
		MODE_WORD_LEFT  = 4'd5,
		MODE_WORD_RIGHT = 4'd6,
		MODE_UP         = 4'd7,
		MODE_DOWN       = 4'd8,
		MODE_HOME       = 4'd9,
		MODE_END        = 4'd10,
		MODE_NEW_LINE   = 4'd11,
		MODE_READ       = 4'd12
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_DONE
	} state_t;

	// shift command broadcast to every cell of the row
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_RIGHT,
		SH_LEFT
	} shift_t;

	localparam logic [7:0] SPACE_CODE    = 8'd32;
	localparam logic [0:0] REG_COLS      = 1'b0;
	localparam logic [0:0] REG_ROWS      = 1'b1;
	localparam logic [7:0] COLS_RESET    = 8'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd25;

endpackage

>>> src/leb_if.sv
// ----------------------------------------------------------------------------
// leb_key_if / leb_res_if / leb_cfg_if
// valid/ready channels of the line edit buffer
// ----------------------------------------------------------------------------
interface leb_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] char_code;
	logic [7:0] start_column;
	logic [7:0] read_index;
	modport source (output valid, mode, char_code, start_column, read_index, input ready);
	modport sink (input valid, mode, char_code, start_column, read_index, output ready);
endinterface

interface leb_res_if;
	logic       valid;
	logic       ready;
	logic [8:0] cursor;
	logic [8:0] length;
	logic       changed;
	logic [7:0] read_char;
	modport source (output valid, cursor, length, changed, read_char, input ready);
	modport sink (input valid, cursor, length, changed, read_char, output ready);
endinterface

interface leb_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_top
// one-line text editor: cursor, length and a row of shifting character cells
// ----------------------------------------------------------------------------
// Each key transfer gives one result transfer. Text lives in a row of
// BUFFER_SIZE cells. An insert or delete shifts every cell from the cursor
// to the end of the text by one place at once (a backspace from one cell
// left of the cursor). Before an insert commits, a page test divides origin
// column + length + 1 by the column count by repeated subtraction, one step
// a cycle. Word moves walk the cursor one cell a cycle. A read picks one
// cell through a multiplexer. One key is worked on at a time; the result
// register is taken by the sink independently of the next key transfer's
// arrival.
module line_edit_buffer_top #(
	parameter int BUFFER_SIZE = 256
) (
	input logic clk,
	input logic arst_n,
	leb_key_if.sink   key,
	leb_cfg_if.sink   cfg,
	leb_res_if.source res
);
	localparam int AW = $clog2(BUFFER_SIZE);
	localparam int PW = AW + 1;

	leb_pkg::state_t state_q, state_d;
	logic [PW-1:0] pos_q, len_q, old_pos_q, old_len_q;
	logic [7:0]    origin_q, cols_q, rows_q;
	logic [3:0]    mode_q;
	logic [7:0]    ch_q, ridx_q;
	logic [7:0]    cells [BUFFER_SIZE];
	logic [7:0]    rd_q;
	logic          fwd_q;

	leb_pkg::shift_t shift;
	logic [BUFFER_SIZE-1:0] shift_en, load_en;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= leb_pkg::COLS_RESET;
			rows_q <= leb_pkg::ROWS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				leb_pkg::REG_COLS: cols_q <= cfg.data;
				leb_pkg::REG_ROWS: rows_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// effective columns and page test for insert
	logic [8:0]  cols;
	logic [PW:0] w;
	logic [PW:0] wq;
	logic        wrem0;
	assign cols = (cols_q == 8'd0) ? 9'd1 : {1'b0, cols_q};
	assign w    = (PW+1)'(origin_q) + (PW+1)'(len_q) + (PW+1)'(1);
	// quotient and remainder of w by repeated subtraction, one step a cycle
	logic [PW:0] div_rem_q, div_quo_q;

	// word walk helpers; the read shares the walk's second cell port
	logic [PW-1:0] pos_m1, pos_p1;
	logic [PW-1:0] walk_p;
	logic [AW-1:0] pick_addr;
	logic [7:0]    pick_char, prev_char;
	logic          edge_next;
	assign pos_m1 = pos_q - PW'(1);
	assign pos_p1 = pos_q + PW'(1);
	assign walk_p = fwd_q ? pos_p1 : pos_m1;
	assign pick_addr = (mode_q == leb_pkg::MODE_READ) ? AW'(ridx_q) : walk_p[AW-1:0];
	assign pick_char = cells[pick_addr];
	assign prev_char = cells[walk_p[AW-1:0] - AW'(1)];
	assign edge_next = (walk_p != '0) && (walk_p < PW'(BUFFER_SIZE)) &&
		(prev_char == leb_pkg::SPACE_CODE) && (pick_char != leb_pkg::SPACE_CODE);

	logic key_fire;
	assign key_fire = key.valid && key.ready;
	assign key.ready = (state_q == leb_pkg::ST_IDLE);

	logic done_work;
	always_comb begin
		done_work = 1'b1;
		unique case (leb_pkg::mode_t'(mode_q))
			leb_pkg::MODE_WORD_LEFT:  done_work = (pos_q == '0) || (pos_m1 == '0) || edge_next;
			leb_pkg::MODE_WORD_RIGHT: done_work = (pos_q >= len_q) || (pos_p1 >= len_q) || edge_next;
			leb_pkg::MODE_INSERT:     done_work = (div_rem_q < (PW+1)'(cols));
			default:                  done_work = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			leb_pkg::ST_IDLE: if (key_fire) state_d = leb_pkg::ST_WORK;
			leb_pkg::ST_WORK: if (done_work) state_d = leb_pkg::ST_DONE;
			leb_pkg::ST_DONE: if (!res.valid || res.ready) state_d = leb_pkg::ST_IDLE;
			default: state_d = leb_pkg::ST_IDLE;
		endcase
	end

	// insert legality once the quotient unit finishes
	logic ins_ok;
	assign wq = div_quo_q + (PW+1)'(1);
	assign wrem0 = (div_rem_q == '0);
	assign ins_ok = (ch_q >= leb_pkg::SPACE_CODE) && (len_q < PW'(BUFFER_SIZE)) &&
		!(wrem0 && wq >= (PW+1)'(rows_q));

	logic commit;
	assign commit = (state_q == leb_pkg::ST_WORK) && done_work;

	// cell row control
	always_comb begin
		shift = leb_pkg::SH_HOLD;
		for (int i = 0; i < BUFFER_SIZE; i++) begin
			shift_en[i] = 1'b0;
			load_en[i]  = 1'b0;
		end
		if (commit) begin
			if (mode_q == leb_pkg::MODE_INSERT && ins_ok) begin
				shift = leb_pkg::SH_RIGHT;
				for (int i = 0; i < BUFFER_SIZE; i++) begin
					shift_en[i] = PW'(i) > pos_q && PW'(i) <= len_q;
					load_en[i]  = PW'(i) == pos_q;
				end
			end else if ((mode_q == leb_pkg::MODE_BACKSPACE && pos_q != '0) ||
				(mode_q == leb_pkg::MODE_DELETE && pos_q < len_q)) begin
				shift = leb_pkg::SH_LEFT;
				for (int i = 0; i < BUFFER_SIZE; i++)
					shift_en[i] = (mode_q == leb_pkg::MODE_DELETE) ?
						(PW'(i) >= pos_q && PW'(i) + PW'(1) < len_q) :
						(PW'(i) + PW'(1) >= pos_q && PW'(i) + PW'(1) < len_q);
			end
		end
	end

	for (genvar g = 0; g < BUFFER_SIZE; g++) begin : g_cell
		leb_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.shift_en   (shift_en[g]),
			.load_en    (load_en[g]),
			.load_char  (ch_q),
			.left_char  (cells[(g == 0) ? 0 : g - 1]),
			.right_char (cells[(g == BUFFER_SIZE - 1) ? g : g + 1]),
			.char_q     (cells[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= leb_pkg::ST_IDLE;
			pos_q <= '0;
			len_q <= '0;
			origin_q <= '0;
			res.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_fire) begin
				mode_q <= key.mode;
				ch_q <= key.char_code;
				ridx_q <= key.read_index;
				fwd_q <= (key.mode == leb_pkg::MODE_WORD_RIGHT);
				old_pos_q <= pos_q;
				old_len_q <= len_q;
				div_rem_q <= w;
				div_quo_q <= '0;
				rd_q <= 8'd0;
				if (key.mode == leb_pkg::MODE_NEW_LINE) origin_q <= key.start_column;
			end
			if (state_q == leb_pkg::ST_WORK) begin
				// quotient unit: one subtract of cols per cycle
				if (mode_q == leb_pkg::MODE_INSERT && !done_work) begin
					div_rem_q <= div_rem_q - (PW+1)'(cols);
					div_quo_q <= div_quo_q + (PW+1)'(1);
				end
				if (mode_q == leb_pkg::MODE_WORD_LEFT && pos_q != '0) pos_q <= pos_m1;
				if (mode_q == leb_pkg::MODE_WORD_RIGHT && pos_q < len_q) pos_q <= pos_p1;
				if (commit) begin
					unique case (leb_pkg::mode_t'(mode_q))
						leb_pkg::MODE_INSERT: if (ins_ok) begin
							pos_q <= pos_p1; len_q <= len_q + PW'(1);
						end
						leb_pkg::MODE_BACKSPACE: if (pos_q != '0) begin
							pos_q <= pos_m1; len_q <= len_q - PW'(1);
						end
						leb_pkg::MODE_DELETE: if (pos_q < len_q) len_q <= len_q - PW'(1);
						leb_pkg::MODE_LEFT: if (pos_q != '0) pos_q <= pos_m1;
						leb_pkg::MODE_RIGHT: if (pos_q < len_q) pos_q <= pos_p1;
						leb_pkg::MODE_UP: if ({1'b0, pos_q} >= (PW+1)'(cols))
							pos_q <= PW'({1'b0, pos_q} - (PW+1)'(cols));
						leb_pkg::MODE_DOWN: if ((PW+1)'(pos_q) + (PW+1)'(cols) <= (PW+1)'(len_q))
							pos_q <= PW'((PW+1)'(pos_q) + (PW+1)'(cols));
						leb_pkg::MODE_HOME: pos_q <= '0;
						leb_pkg::MODE_END: pos_q <= len_q;
						leb_pkg::MODE_NEW_LINE: begin pos_q <= '0; len_q <= '0; end
						leb_pkg::MODE_READ: if (PW'(ridx_q) < len_q)
							rd_q <= pick_char;
						default: ;
					endcase
				end
			end
			if (state_q == leb_pkg::ST_DONE && (!res.valid || res.ready))
				res.valid <= 1'b1;
			else if (res.valid && res.ready)
				res.valid <= 1'b0;
		end
	end

	// result register, loaded when the done state hands over
	always_ff @(posedge clk) begin
		if (state_q == leb_pkg::ST_DONE && (!res.valid || res.ready)) begin
			res.cursor    <= 9'(pos_q);
			res.length    <= 9'(len_q);
			res.changed   <= (pos_q != old_pos_q) || (len_q != old_len_q);
			res.read_char <= rd_q;
		end
	end

`ifndef SYNTHESIS
	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q) else $error("cursor beyond length");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PW'(BUFFER_SIZE)) else $error("length beyond buffer");
	a_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		key_fire |=> state_q == leb_pkg::ST_WORK) else $error("key not taken to work");
`endif
endmodule

>>> src/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell
// one character cell: loads from its left or right neighbor or the key
// ----------------------------------------------------------------------------
module leb_cell (
	input  logic            clk,
	input  leb_pkg::shift_t shift,
	input  logic            shift_en,
	input  logic            load_en,
	input  logic [7:0]      load_char,
	input  logic [7:0]      left_char,
	input  logic [7:0]      right_char,
	output logic [7:0]      char_q
);
	always_ff @(posedge clk) begin
		if (load_en) begin
			char_q <= load_char;
		end else if (shift_en) begin
			case (shift)
				leb_pkg::SH_RIGHT: char_q <= left_char;
				leb_pkg::SH_LEFT:  char_q <= right_char;
				default:           char_q <= char_q;
			endcase
		end
	end
endmodule

>>> tb/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker
// watches the key, config and result channels, predicts and compares
// ----------------------------------------------------------------------------
module leb_checker #(
	parameter int BUFFER_SIZE = 256
) (
	input  logic clk,
	input  logic arst_n,
	leb_key_if   key,
	leb_cfg_if   cfg,
	leb_res_if   res,
	output int   fails,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [8:0] cursor;
		logic [8:0] length;
		logic       changed;
		logic [7:0] read_char;
	} edit_view_t;

	logic [7:0] line_text [BUFFER_SIZE];
	int         cur_pos;
	int         char_total;
	int         origin_col;
	logic [7:0] width_cols;
	logic [7:0] height_rows;
	edit_view_t view_queue [$];

	function automatic bit at_word_start(int p);
		return line_text[p-1] == leb_pkg::SPACE_CODE && line_text[p] != leb_pkg::SPACE_CODE;
	endfunction

	function automatic edit_view_t edit_line(logic [3:0] op, logic [7:0] ch,
			logic [7:0] scol, logic [7:0] ridx);
		int         old_pos, old_len, cols, w;
		logic [7:0] rd;
		old_pos = cur_pos;
		old_len = char_total;
		cols = (width_cols == 0) ? 1 : int'(width_cols);
		rd = 8'd0;
		case (op)
			leb_pkg::MODE_INSERT: begin
				w = origin_col + char_total + 1;
				if (ch >= leb_pkg::SPACE_CODE && char_total < BUFFER_SIZE &&
						!(w % cols == 0 && w / cols + 1 >= int'(height_rows))) begin
					for (int i = char_total; i > cur_pos; i--)
						line_text[i] = line_text[i-1];
					line_text[cur_pos] = ch;
					cur_pos++;
					char_total++;
				end
			end
			leb_pkg::MODE_BACKSPACE, leb_pkg::MODE_DELETE: begin
				if (op == leb_pkg::MODE_DELETE && cur_pos < char_total)
					cur_pos++;
				if (cur_pos > 0 && (op == leb_pkg::MODE_BACKSPACE || cur_pos != old_pos)) begin
					for (int i = cur_pos; i < char_total; i++)
						line_text[i-1] = line_text[i];
					cur_pos--;
					char_total--;
				end
			end
			leb_pkg::MODE_LEFT:  if (cur_pos > 0) cur_pos--;
			leb_pkg::MODE_RIGHT: if (cur_pos < char_total) cur_pos++;
			leb_pkg::MODE_WORD_LEFT: begin
				if (cur_pos > 0) begin
					do cur_pos--; while (cur_pos > 0 && !at_word_start(cur_pos));
				end
			end
			leb_pkg::MODE_WORD_RIGHT: begin
				if (cur_pos < char_total) begin
					do cur_pos++; while (cur_pos < char_total && !at_word_start(cur_pos));
				end
			end
			leb_pkg::MODE_UP:   if (cur_pos >= cols) cur_pos -= cols;
			leb_pkg::MODE_DOWN: if (cur_pos + cols <= char_total) cur_pos += cols;
			leb_pkg::MODE_HOME: cur_pos = 0;
			leb_pkg::MODE_END:  cur_pos = char_total;
			leb_pkg::MODE_NEW_LINE: begin
				origin_col = int'(scol);
				cur_pos = 0;
				char_total = 0;
			end
			leb_pkg::MODE_READ: if (int'(ridx) < char_total) rd = line_text[ridx];
			default: ;
		endcase
		return '{cursor: cur_pos[8:0], length: char_total[8:0],
			changed: (cur_pos != old_pos || char_total != old_len), read_char: rd};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edit_view_t want;
		if (!arst_n) begin
			cur_pos = 0;
			char_total = 0;
			origin_col = 0;
			width_cols = leb_pkg::COLS_RESET;
			height_rows = leb_pkg::ROWS_RESET;
			view_queue.delete();
			fails = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == leb_pkg::REG_COLS)
					width_cols = cfg.data;
				else if (cfg.index == leb_pkg::REG_ROWS)
					height_rows = cfg.data;
			end
			if (key.valid && key.ready)
				view_queue.push_back(edit_line(key.mode, key.char_code,
					key.start_column, key.read_index));
			if (res.valid && res.ready) begin
				if (view_queue.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t unexpected result cursor=%0d length=%0d", $realtime,
							res.cursor, res.length);
				end else begin
					want = view_queue.pop_front();
					if (res.cursor !== want.cursor || res.length !== want.length ||
							res.changed !== want.changed || res.read_char !== want.read_char) begin
						fails++;
						if (fails <= 10)
							$display({"%t mismatch exp cur=%0d len=%0d chg=%0b rd=%0d",
								" got cur=%0d len=%0d chg=%0b rd=%0d"},
								$realtime, want.cursor, want.length, want.changed, want.read_char,
								res.cursor, res.length, res.changed, res.read_char);
					end
				end
			end
		end
		pending = view_queue.size();
	end
endmodule

>>> tb/tb_line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_line_edit_buffer_top
// random key stream against the line edit buffer under several screen sizes
// ----------------------------------------------------------------------------
// Directed keys cover every mode, control and edge cases, then phases of
// random keys run with different screen sizes. A checker beside the block
// predicts each result and counts failures.
module tb_line_edit_buffer_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   busy_mode;   // no idling on either side while set

	leb_key_if key ();
	leb_cfg_if cfg ();
	leb_res_if res ();

	line_edit_buffer_top dut (.clk(clk), .arst_n(arst_n), .key(key), .cfg(cfg), .res(res));
	leb_checker checker_i (.clk(clk), .arst_n(arst_n), .key(key), .cfg(cfg), .res(res),
		.fails(fails), .pending(pending));

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (busy_mode || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= busy_mode ? 1'b1 : ($urandom_range(0, 99) < 70);
		end
	end

	// valid stays high across back-to-back transfers
	task automatic key_send(logic [3:0] op, logic [7:0] ch, logic [7:0] scol, logic [7:0] ridx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			key.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key.valid <= 1'b1;
		key.mode <= op;
		key.char_code <= ch;
		key.start_column <= scol;
		key.read_index <= ridx;
		@(posedge clk);
		while (!key.ready) @(posedge clk);
	endtask

	// register write only when the block has nothing in flight
	task automatic cfg_write(logic [0:0] idx, logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		key.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return leb_pkg::SPACE_CODE;
		if (r < 30) return 8'($urandom_range(0, 31));
		return 8'($urandom_range(33, 255));
	endfunction

	task automatic rand_key();
		int         r;
		logic [3:0] op;
		logic [7:0] ridx;
		r = $urandom_range(0, 99);
		if (r < 45) op = leb_pkg::MODE_INSERT;
		else if (r < 47) op = leb_pkg::MODE_NEW_LINE;
		else if (r < 49) op = 4'($urandom_range(13, 15));
		else op = 4'($urandom_range(1, 12));
		if (op == leb_pkg::MODE_NEW_LINE && $urandom_range(0, 1)) op = leb_pkg::MODE_READ;
		ridx = $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
		key_send(op, rand_char(), 8'($urandom_range(0, 254)), ridx);
	endtask

	initial begin
		logic [7:0] col_set [8] = '{8'd255, 8'd0, 8'd1, 8'd4, 8'd7, 8'd16, 8'd80, 8'd3};
		logic [7:0] row_set [8] = '{8'd255, 8'd0, 8'd255, 8'd3, 8'd5, 8'd20, 8'd25, 8'd170};
		busy_mode = 1'b0;
		arst_n = 1'b0;
		key.valid = 1'b0; key.mode = '0; key.char_code = '0;
		key.start_column = '0; key.read_index = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edges on an empty line, control and printable extremes, all modes
		key_send(leb_pkg::MODE_NEW_LINE, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_BACKSPACE, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_DELETE, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd31, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd32, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd255, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd65, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd32, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_INSERT, 8'd66, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_WORD_LEFT, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_LEFT, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_WORD_RIGHT, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_HOME, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_DELETE, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_RIGHT, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_UP, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_DOWN, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_END, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_READ, 8'd0, 8'd0, 8'd1);
		key_send(leb_pkg::MODE_READ, 8'd0, 8'd0, 8'd255);
		key_send(4'd15, 8'd0, 8'd0, 8'd0);
		key_send(leb_pkg::MODE_NEW_LINE, 8'd0, 8'd254, 8'd0);

		// each phase: wait idle, new screen size, a new line, then random keys
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			cfg_write(leb_pkg::REG_COLS, col_set[ph]);
			cfg_write(leb_pkg::REG_ROWS, row_set[ph]);
			busy_mode = (ph % 3 == 1);
			key_send(leb_pkg::MODE_NEW_LINE, 8'd0,
				(ph == 0) ? 8'd0 : 8'($urandom_range(0, 254)), 8'd0);
			// widest screen: fill the buffer to its end and past it
			if (ph == 0) begin
				for (int i = 0; i < 260; i++)
					key_send(leb_pkg::MODE_INSERT, rand_char() | 8'd32, 8'd0, 8'd0);
				key_send(leb_pkg::MODE_READ, 8'd0, 8'd0, 8'd255);
			end
			for (int i = 0; i < 160; i++)
				rand_key();
		end

		key.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fails == 0)
			$display("line_edit_buffer_top verification clean");
		else
			$display("line_edit_buffer_top verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("line_edit_buffer_top verification failed");
		$finish;
	end
endmodule

>>> line_edit_buffer_top.f
src/leb_pkg.sv
src/leb_if.sv
src/leb_cell.sv
src/line_edit_buffer_top.sv
tb/leb_checker.sv
tb/tb_line_edit_buffer_top.sv
